[rtl/core/dlle_pkg.sv]
// Shared types and constants for the doubly linked list engine.
`default_nettype none
package dlle_pkg;
  localparam int OP_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_CLEAR    = 5'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 5'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 5'd2;
  localparam logic [OP_W-1:0] OP_CUR_HEAD = 5'd3;
  localparam logic [OP_W-1:0] OP_CUR_TAIL = 5'd4;
  localparam logic [OP_W-1:0] OP_RD_HEAD  = 5'd5;
  localparam logic [OP_W-1:0] OP_RD_TAIL  = 5'd6;
  localparam logic [OP_W-1:0] OP_DEL_HEAD = 5'd7;
  localparam logic [OP_W-1:0] OP_DEL_TAIL = 5'd8;
  localparam logic [OP_W-1:0] OP_DEL_AFT  = 5'd9;
  localparam logic [OP_W-1:0] OP_DEL_BEF  = 5'd10;
  localparam logic [OP_W-1:0] OP_INS_AFT  = 5'd11;
  localparam logic [OP_W-1:0] OP_INS_BEF  = 5'd12;
  localparam logic [OP_W-1:0] OP_RD_CUR   = 5'd13;
  localparam logic [OP_W-1:0] OP_WR_CUR   = 5'd14;
  localparam logic [OP_W-1:0] OP_NEXT     = 5'd15;
  localparam logic [OP_W-1:0] OP_PREV     = 5'd16;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request
    logic fetch;    // read memories at the first operand
    logic link;     // read links of the fetched node's neighbours
    logic execute;  // do the link update
    logic emit;     // present result
  } dlle_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } dlle_stat_t;
endpackage
`default_nettype wire

[rtl/core/dlle_ctrl.sv]
// Sequencer stepping each request through load, fetch, link, execute and emit.
`default_nettype none
module dlle_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dlle_pkg::dlle_stat_t stat,
  output dlle_pkg::dlle_cmd_t     cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.link = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: if (!stat.out_busy) begin
        cmd.emit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_emit_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy) else $error("emit while output held");
  a_load_then_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.fetch) else $error("fetch did not follow load");
  a_fetch_then_link: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> cmd.link) else $error("link read did not follow fetch");
  a_link_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.link |=> cmd.execute) else $error("execute did not follow link read");
endmodule
`default_nettype wire

[rtl/core/dlle_dp.sv]
// Node pool memories, list pointers, free-slot search and result register.
`default_nettype none
module dlle_dp #(
  parameter int LIST_NODES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dlle_pkg::dlle_cmd_t       cmd,
  output dlle_pkg::dlle_stat_t           stat,
  input  wire logic [dlle_pkg::OP_W-1:0] op_in,
  input  wire logic [dlle_pkg::VAL_W-1:0] value_in,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [dlle_pkg::VAL_W-1:0]     read_value,
  output logic [dlle_pkg::ST_W-1:0]      status,
  output logic                           cursor_valid
);
  localparam int AW = $clog2(LIST_NODES);
  localparam int PW = $clog2(LIST_NODES + 1);   // pointer with null code
  localparam logic [PW-1:0] NIL = PW'(LIST_NODES);

  logic [dlle_pkg::VAL_W-1:0] mem_val [LIST_NODES];
  logic [PW-1:0] mem_next [LIST_NODES];
  logic [PW-1:0] mem_prev [LIST_NODES];
  logic [LIST_NODES-1:0] used;
  logic [PW-1:0] head, tail, cur;

  logic [dlle_pkg::OP_W-1:0] op;
  logic [dlle_pkg::VAL_W-1:0] val;
  logic [PW-1:0] a_ptr;              // node whose links are read
  logic [dlle_pkg::VAL_W-1:0] a_val;
  logic [PW-1:0] a_next, a_prev;
  logic [PW-1:0] b_next, b_prev;     // links of cursor neighbour (second read)
  logic [PW-1:0] free_idx;
  logic [dlle_pkg::VAL_W-1:0] r_val;
  logic [dlle_pkg::ST_W-1:0] r_st;
  logic [dlle_pkg::VAL_W-1:0] res_val;
  logic [dlle_pkg::ST_W-1:0] res_st;

  function automatic logic is_node(input logic [PW-1:0] p);
    return p < NIL;
  endfunction

  // lowest free slot, priority encoder
  always_comb begin
    free_idx = NIL;
    for (int k = LIST_NODES - 1; k >= 0; k--)
      if (!used[k]) free_idx = PW'(k);
  end

  // pick node to fetch
  logic [PW-1:0] f_ptr;
  always_comb begin
    unique case (op)
      dlle_pkg::OP_RD_HEAD, dlle_pkg::OP_DEL_HEAD: f_ptr = head;
      dlle_pkg::OP_RD_TAIL, dlle_pkg::OP_DEL_TAIL: f_ptr = tail;
      default: f_ptr = cur;
    endcase
  end

  // delete target and its links, resolved in execute
  logic [PW-1:0] d_ptr, d_prev, d_next;
  logic d_en;
  // insert neighbours
  logic [PW-1:0] i_p, i_n;
  logic i_en;
  always_comb begin
    d_en = 1'b0; d_ptr = NIL; d_prev = a_prev; d_next = a_next;
    i_en = 1'b0; i_p = NIL; i_n = NIL;
    unique case (op)
      dlle_pkg::OP_DEL_HEAD, dlle_pkg::OP_DEL_TAIL: begin
        d_en = is_node(a_ptr); d_ptr = a_ptr;
      end
      dlle_pkg::OP_DEL_AFT: begin
        d_en = is_node(a_ptr) && is_node(a_next);
        d_ptr = a_next; d_prev = a_ptr; d_next = b_next;
      end
      dlle_pkg::OP_DEL_BEF: begin
        d_en = is_node(a_ptr) && is_node(a_prev);
        d_ptr = a_prev; d_next = a_ptr; d_prev = b_prev;
      end
      dlle_pkg::OP_INS_HEAD: begin i_en = 1'b1; i_n = head; end
      dlle_pkg::OP_INS_TAIL: begin i_en = 1'b1; i_p = tail; end
      dlle_pkg::OP_INS_AFT: begin
        i_en = is_node(a_ptr); i_p = a_ptr; i_n = a_next;
      end
      dlle_pkg::OP_INS_BEF: begin
        i_en = is_node(a_ptr); i_p = a_prev; i_n = a_ptr;
      end
      default: ;
    endcase
  end

  // result of the request, taken in execute
  always_comb begin
    res_val = '0;
    res_st = dlle_pkg::ST_OK;
    unique case (op)
      dlle_pkg::OP_RD_HEAD, dlle_pkg::OP_RD_TAIL, dlle_pkg::OP_RD_CUR: begin
        if (is_node(a_ptr)) res_val = a_val;
        else res_st = dlle_pkg::ST_EMPTY;
      end
      default: ;
    endcase
    if (i_en && !is_node(free_idx)) res_st = dlle_pkg::ST_FULL;
  end

  logic [AW-1:0] an_a, ap_a;
  assign an_a = a_next[AW-1:0];
  assign ap_a = a_prev[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_in;
      val <= value_in;
    end
    if (cmd.fetch) begin
      a_ptr <= f_ptr;
      if (is_node(f_ptr)) begin
        a_val <= mem_val[f_ptr[AW-1:0]];
        a_next <= mem_next[f_ptr[AW-1:0]];
        a_prev <= mem_prev[f_ptr[AW-1:0]];
      end else begin
        a_val <= '0; a_next <= NIL; a_prev <= NIL;
      end
    end
    // second read, in the cycle after the fetch: links of cursor neighbour
    if (cmd.link) begin
      b_next <= is_node(a_next) ? mem_next[an_a] : NIL;
      b_prev <= is_node(a_prev) ? mem_prev[ap_a] : NIL;
    end
    if (cmd.execute && d_en) begin
      if (is_node(d_prev)) mem_next[d_prev[AW-1:0]] <= d_next;
      if (is_node(d_next)) mem_prev[d_next[AW-1:0]] <= d_prev;
    end
    if (cmd.execute && i_en && is_node(free_idx)) begin
      mem_val[free_idx[AW-1:0]] <= val;
      mem_prev[free_idx[AW-1:0]] <= i_p;
      mem_next[free_idx[AW-1:0]] <= i_n;
      if (is_node(i_p)) mem_next[i_p[AW-1:0]] <= free_idx;
      if (is_node(i_n)) mem_prev[i_n[AW-1:0]] <= free_idx;
    end
    if (cmd.execute && op == dlle_pkg::OP_WR_CUR && is_node(cur))
      mem_val[cur[AW-1:0]] <= val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0; head <= NIL; tail <= NIL; cur <= NIL;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        read_value <= r_val;
        status <= r_st;
        cursor_valid <= is_node(cur);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.execute) begin
        r_val <= res_val;
        r_st <= res_st;
        unique case (op)
          dlle_pkg::OP_CLEAR: begin
            used <= '0; head <= NIL; tail <= NIL; cur <= NIL;
          end
          dlle_pkg::OP_CUR_HEAD: cur <= head;
          dlle_pkg::OP_CUR_TAIL: cur <= tail;
          dlle_pkg::OP_NEXT: if (is_node(cur)) cur <= a_next;
          dlle_pkg::OP_PREV: if (is_node(cur)) cur <= a_prev;
          default: ;
        endcase
        if (d_en) begin
          used[d_ptr[AW-1:0]] <= 1'b0;
          if (!is_node(d_prev)) head <= d_next;
          if (!is_node(d_next)) tail <= d_prev;
          if (cur == d_ptr) cur <= NIL;
        end
        if (i_en && is_node(free_idx)) begin
          used[free_idx[AW-1:0]] <= 1'b1;
          if (!is_node(i_p)) head <= free_idx;
          if (!is_node(i_n)) tail <= free_idx;
        end
      end
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

  a_head_tail_null: assert property (@(posedge clk) disable iff (rst)
    (head == NIL) == (tail == NIL)) else $error("head/tail null mismatch");
  a_empty_pool: assert property (@(posedge clk) disable iff (rst)
    (used == '0) |-> (head == NIL)) else $error("head set on empty pool");
  a_cur_used: assert property (@(posedge clk) disable iff (rst)
    is_node(cur) |-> used[cur[AW-1:0]]) else $error("cursor on free slot");
endmodule
`default_nettype wire

[rtl/core/doubly_linked_list_engine.sv]
// Top level of the doubly linked list engine.
// Usage:
//  - s_axis: one request per handshake. tdata = {value[31:0], op[4:0]}
//    with op in bits 4:0 and value in bits 36:5, zero filled to 40 bits.
//  - m_axis: one result per request. tdata = read_value in bits 31:0,
//    status in 33:32, cursor_valid in bit 34, zero filled to 40 bits.
//  - Each request steps through capture, node fetch, neighbour link
//    fetch, link update and result register, an order set by the
//    registered reads of node memory, the second addressed by the first.
//  - The result is registered when the sequencer emits; a new request
//    is taken only once the previous result has been emitted.
//  - When m_axis stalls the sequencer holds before emitting and
//    s_axis_tready stays low; no request is dropped.
//  - Reset (rst, synchronous) empties the pool and nulls head, tail and
//    cursor at once; node memory itself is not cleared.
//  - The lowest free slot takes each new node; a full pool returns status 2.
`default_nettype none
module doubly_linked_list_engine #(
  parameter int LIST_NODES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // op[4:0], value[36:5]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // read_value[31:0], status[33:32], cursor_valid[34]
);
  dlle_pkg::dlle_cmd_t cmd;
  dlle_pkg::dlle_stat_t stat;
  logic [31:0] rv;
  logic [1:0] st;
  logic cv;

  dlle_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .stat(stat), .cmd(cmd)
  );

  dlle_dp #(.LIST_NODES(LIST_NODES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .op_in(s_axis_tdata[4:0]), .value_in(s_axis_tdata[36:5]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .read_value(rv), .status(st), .cursor_valid(cv)
  );

  assign m_axis_tdata = {5'd0, cv, st, rv};
endmodule
`default_nettype wire
